FILE: sv/iau_pkg.sv
// types, constants and helper functions shared by the interval arithmetic unit
package iau_pkg;

   localparam int W      = 32;
   localparam int FRAC   = 16;
   localparam int QBITS  = W + FRAC;          // quotient bits produced by the cell row
   localparam int FUNC_W = 4;
   localparam int NQ     = 4;                 // four quotients side by side

   typedef enum logic [3:0] {
      FN_ADD = 4'd0,
      FN_SUB = 4'd1,
      FN_MUL = 4'd2,
      FN_DIV = 4'd3,
      FN_INV = 4'd4,
      FN_INC = 4'd5,
      FN_DEC = 4'd6,
      FN_NEG = 4'd7,
      FN_CMP = 4'd8
   } func_type;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_OVF  = 2'd1;
   localparam logic [1:0] ERR_DIV0 = 2'd2;

   localparam logic [7:0] F_EQ  = 8'h01;
   localparam logic [7:0] F_NE  = 8'h02;
   localparam logic [7:0] F_GT  = 8'h04;
   localparam logic [7:0] F_GE  = 8'h08;
   localparam logic [7:0] F_LT  = 8'h10;
   localparam logic [7:0] F_LE  = 8'h20;
   localparam logic [7:0] F_IN  = 8'h40;
   localparam logic [7:0] F_OUT = 8'h80;

   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = W'(64'd1 << FRAC);

   // per-item info that travels beside the data down the cell row
   typedef struct packed {
      logic [3:0]          func;
      logic signed [W-1:0] r_low;
      logic signed [W-1:0] r_upp;
      logic [7:0]          flags;
      logic [1:0]          err;
      logic                div0;
   } side_type;

   // one quotient lane: remainder, partial quotient, divisor, numerator bits, result sign
   typedef struct packed {
      logic [W:0]       rem;
      logic [QBITS-1:0] quo;
      logic [W-1:0]     den;
      logic [QBITS-1:0] num;
      logic             neg;
   } lane_type;

   function automatic logic [W-1:0] magn(input logic signed [W-1:0] x);
      magn = x[W-1] ? W'(-x) : x;
   endfunction

   // saturating pack of a sign and magnitude with floor rounding
   function automatic logic [W:0] pack_val(input logic neg, input logic [2*W:0] m,
                                           input logic frac);
      logic [2*W+1:0] mm;
      logic signed [W-1:0] v;
      logic ovf;
      begin
         mm  = {1'b0, m} + ((neg && frac) ? (2*W+2)'(1) : '0);
         ovf = 1'b0;
         v   = '0;
         if (!neg) begin
            if (mm > (2*W+2)'(MAXV)) begin
               ovf = 1'b1;
               v = MAXV;
            end else begin
               v = W'(mm);
            end
         end else begin
            if (mm > (2*W+2)'(MAXV) + (2*W+2)'(1)) begin
               ovf = 1'b1;
               v = MINV;
            end else begin
               v = W'(-mm);
            end
         end
         pack_val = {ovf, v};
      end
   endfunction

   function automatic logic [7:0] cmp_of(input logic signed [W-1:0] al,
                                         input logic signed [W-1:0] au,
                                         input logic signed [W-1:0] bl,
                                         input logic signed [W-1:0] bu);
      if (al == bl && au == bu)      cmp_of = F_EQ | F_GE | F_LE | F_IN | F_OUT;
      else if (al >= bu)             cmp_of = F_GT | F_NE;
      else if (al >= bl && au >= bu) cmp_of = F_GE;
      else if (au <= bl)             cmp_of = F_LT | F_NE;
      else if (al <= bl && au <= bu) cmp_of = F_LE;
      else if (al >= bl && au <= bu) cmp_of = F_IN;
      else if (al <= bl && au >= bu) cmp_of = F_OUT;
      else                           cmp_of = 8'h00;
   endfunction

endpackage

FILE: sv/iau_div_cell.sv
// one restoring-division cell: one quotient bit per lane, registered
module iau_div_cell
   import iau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  logic                   enable,
   input  lane_type [NQ-1:0]      lane_in,
   input  side_type               side_in,
   input  logic [NQ-1:0][2*W-1:0] prod_in,
   output logic                   valid_out,
   output lane_type [NQ-1:0]      lane_out,
   output side_type               side_out,
   output logic [NQ-1:0][2*W-1:0] prod_out
);

   logic                   valid_ff;
   lane_type [NQ-1:0]      lane_ff, lane_in_nx;
   side_type               side_ff;
   logic [NQ-1:0][2*W-1:0] prod_ff;

   always_comb begin
      logic [W+1:0] trial;
      for (int i = 0; i < NQ; i++) begin
         lane_in_nx[i]     = lane_in[i];
         trial             = {lane_in[i].rem, lane_in[i].num[QBITS-1]};
         lane_in_nx[i].num = {lane_in[i].num[QBITS-2:0], 1'b0};
         if (trial >= {2'b00, lane_in[i].den}) begin
            lane_in_nx[i].rem = (W+1)'(trial - {2'b00, lane_in[i].den});
            lane_in_nx[i].quo = {lane_in[i].quo[QBITS-2:0], 1'b1};
         end else begin
            lane_in_nx[i].rem = (W+1)'(trial);
            lane_in_nx[i].quo = {lane_in[i].quo[QBITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         lane_ff <= lane_in_nx;
         side_ff <= side_in;
         prod_ff <= prod_in;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;
   assign side_out  = side_ff;
   assign prod_out  = prod_ff;

endmodule

FILE: sv/iau_front.sv
// entry stage: add/sub/neg/inc/dec/cmp, four product operand pairs, division lane setup
module iau_front
   import iau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   valid_in,
   input  logic [3:0]             func,
   input  logic signed [W-1:0]    a_low,
   input  logic signed [W-1:0]    a_upp,
   input  logic signed [W-1:0]    b_low,
   input  logic signed [W-1:0]    b_upp,
   output logic                   valid_out,
   output lane_type [NQ-1:0]      lane_out,
   output side_type               side_out,
   output logic [NQ-1:0][2*W-1:0] prod_out
);

   logic                   valid_ff;
   lane_type [NQ-1:0]      lane_ff, lane_in;
   side_type               side_ff, side_in;
   logic [NQ-1:0][2*W-1:0] prod_ff, prod_in;

   function automatic logic [W:0] sadd(input logic signed [W-1:0] x,
                                       input logic signed [W-1:0] y);
      logic signed [W:0] s;
      begin
         s = {x[W-1], x} + {y[W-1], y};
         if (s > (W+1)'(MAXV))       sadd = {1'b1, MAXV};
         else if (s < $signed({MINV[W-1], MINV})) sadd = {1'b1, MINV};
         else                        sadd = {1'b0, s[W-1:0]};
      end
   endfunction

   function automatic logic [W:0] ssub(input logic signed [W-1:0] x,
                                       input logic signed [W-1:0] y);
      logic signed [W:0] s;
      begin
         s = {x[W-1], x} - {y[W-1], y};
         if (s > (W+1)'(MAXV))       ssub = {1'b1, MAXV};
         else if (s < $signed({MINV[W-1], MINV})) ssub = {1'b1, MINV};
         else                        ssub = {1'b0, s[W-1:0]};
      end
   endfunction

   always_comb begin
      logic [W:0] lo, hi;
      logic signed [W-1:0] nn [NQ];
      logic signed [W-1:0] dd [NQ];
      logic signed [W-1:0] ma [NQ];
      logic signed [W-1:0] mb [NQ];
      side_in = '0;
      side_in.func = func;
      lo = '0;
      hi = '0;
      unique case (func)
         FN_ADD: begin lo = sadd(a_low, b_low); hi = sadd(a_upp, b_upp); end
         FN_SUB: begin lo = ssub(a_low, b_upp); hi = ssub(a_upp, b_low); end
         FN_INC: begin lo = sadd(a_low, ONE); hi = sadd(a_upp, ONE); end
         FN_DEC: begin lo = ssub(a_low, ONE); hi = ssub(a_upp, ONE); end
         FN_NEG: begin lo = ssub('0, a_upp); hi = ssub('0, a_low); end
         FN_CMP: side_in.flags = cmp_of(a_low, a_upp, b_low, b_upp);
         default: ;
      endcase
      side_in.r_low = lo[W-1:0];
      side_in.r_upp = hi[W-1:0];
      side_in.err   = (lo[W] || hi[W]) ? ERR_OVF : ERR_NONE;
      side_in.div0  = (func == FN_DIV && (b_low == '0 || b_upp == '0)) ||
                      (func == FN_INV && (a_low == '0 || a_upp == '0));
      // quotient lanes; for inv only lanes 0 and 1 matter (1/a_upp, 1/a_low)
      if (func == FN_INV) begin
         nn[0] = ONE; dd[0] = a_upp; nn[1] = ONE; dd[1] = a_low;
         nn[2] = ONE; dd[2] = a_upp; nn[3] = ONE; dd[3] = a_low;
      end else begin
         nn[0] = a_low; dd[0] = b_low; nn[1] = a_low; dd[1] = b_upp;
         nn[2] = a_upp; dd[2] = b_low; nn[3] = a_upp; dd[3] = b_upp;
      end
      ma[0] = a_low; mb[0] = b_low; ma[1] = a_low; mb[1] = b_upp;
      ma[2] = a_upp; mb[2] = b_low; ma[3] = a_upp; mb[3] = b_upp;
      for (int i = 0; i < NQ; i++) begin
         lane_in[i].rem = '0;
         lane_in[i].quo = '0;
         lane_in[i].den = magn(dd[i]);
         lane_in[i].num = QBITS'({magn(nn[i]), {FRAC{1'b0}}});
         lane_in[i].neg = nn[i][W-1] ^ dd[i][W-1];
         prod_in[i]     = {W'(magn(ma[i])), W'(magn(mb[i]))};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         lane_ff <= lane_in;
         side_ff <= side_in;
         prod_ff <= prod_in;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;
   assign side_out  = side_ff;
   assign prod_out  = prod_ff;

endmodule

FILE: sv/iau_back.sv
// exit stages: multiply, pack with floor rounding, min/max selection
module iau_back
   import iau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   valid_in,
   input  lane_type [NQ-1:0]      lane_in,
   input  side_type               side_in,
   input  logic [NQ-1:0][2*W-1:0] prod_in,
   output logic                   valid_out,
   output logic signed [W-1:0]    r_low,
   output logic signed [W-1:0]    r_upp,
   output logic [7:0]             cmp_flags,
   output logic [1:0]             error
);

   // stage 1: registered products and packed quotients
   logic                 v1_ff;
   side_type             s1_ff;
   logic [2*W-1:0]       p_ff [NQ];
   logic [NQ-1:0]        pneg_ff;
   logic [W:0]           q_ff [NQ];
   // stage 2: packed values
   logic                 v2_ff;
   side_type             s2_ff;
   logic [W:0]           val_ff [NQ];
   logic [W:0]           val_in [NQ];
   // stage 3: output register
   logic                 v3_ff;
   logic signed [W-1:0]  rl_ff, ru_ff;
   logic [7:0]           fl_ff;
   logic [1:0]           er_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ff <= side_in;
         for (int i = 0; i < NQ; i++) begin
            p_ff[i]    <= prod_in[i][2*W-1:W] * prod_in[i][W-1:0];
            pneg_ff[i] <= lane_in[i].neg;
            q_ff[i]    <= pack_val(lane_in[i].neg, (2*W+1)'(lane_in[i].quo),
                                   lane_in[i].rem != '0);
         end
      end
   end

   // sign of each product comes from the original operands, carried as lane neg
   // only when func is mul; lane neg for mul lanes equals sign(a)^sign(b)
   always_comb begin
      logic [2*W:0] sh;
      for (int i = 0; i < NQ; i++) begin
         sh = (2*W+1)'(p_ff[i] >> FRAC);
         if (s1_ff.func == FN_MUL) begin
            val_in[i] = pack_val(pneg_ff[i], sh,
                                 (p_ff[i] & ((2*W)'(1) << FRAC) - (2*W)'(1)) != '0);
         end else begin
            val_in[i] = q_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_ff <= s1_ff;
         for (int i = 0; i < NQ; i++) val_ff[i] <= val_in[i];
      end
   end

   logic signed [W-1:0] mn, mx;
   logic                anyovf;
   always_comb begin
      mn = val_ff[0][W-1:0];
      mx = val_ff[0][W-1:0];
      anyovf = 1'b0;
      for (int i = 0; i < NQ; i++) begin
         if ($signed(val_ff[i][W-1:0]) < mn) mn = val_ff[i][W-1:0];
         if ($signed(val_ff[i][W-1:0]) > mx) mx = val_ff[i][W-1:0];
         anyovf |= val_ff[i][W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (enable) begin
         fl_ff <= s2_ff.flags;
         if ((s2_ff.func == FN_DIV || s2_ff.func == FN_INV) && s2_ff.div0) begin
            rl_ff <= MINV;
            ru_ff <= MAXV;
            er_ff <= ERR_DIV0;
         end else if (s2_ff.func == FN_MUL || s2_ff.func == FN_DIV) begin
            rl_ff <= mn;
            ru_ff <= mx;
            er_ff <= anyovf ? ERR_OVF : ERR_NONE;
         end else if (s2_ff.func == FN_INV) begin
            rl_ff <= val_ff[0][W-1:0];
            ru_ff <= val_ff[1][W-1:0];
            er_ff <= (val_ff[0][W] || val_ff[1][W]) ? ERR_OVF : ERR_NONE;
         end else begin
            rl_ff <= s2_ff.r_low;
            ru_ff <= s2_ff.r_upp;
            er_ff <= s2_ff.err;
         end
      end
   end

   assign valid_out = v3_ff;
   assign r_low     = rl_ff;
   assign r_upp     = ru_ff;
   assign cmp_flags = fl_ff;
   assign error     = er_ff;

endmodule

FILE: sv/interval_arithmetic_unit.sv
// top level of the interval arithmetic unit: front stage, divider cell row, back stages
//
// channel | dir | word                                        | handshake
// req     | in  | func, a_low, a_upp, b_low, b_upp (136 bits) | req_tvalid / req_tready
// rsp     | out | r_low, r_upp, cmp_flags, error (80 bits)    | rsp_tvalid / rsp_tready
//
// one word enters per cycle unless the output stalls; in the row of division cells,
// each cell gives one quotient bit for all four lanes
// the whole pipe advances together; it stalls only while the output word is held
// synchronous active-high reset clears all valid bits, payload is not reset
// req_tready = rsp_tready or output register empty
// value width and fraction bits are the package constants W and FRAC

module interval_arithmetic_unit
   import iau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // func[3:0], a_low, a_upp, b_low, b_upp, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata    // r_low, r_upp, cmp_flags, error, pad
);

   localparam int NCELL = QBITS;

   logic enable;
   logic vf;
   lane_type [NQ-1:0]      lf;
   side_type               sf;
   logic [NQ-1:0][2*W-1:0] pf;

   logic                   vc [NCELL+1];
   lane_type [NQ-1:0]      lc [NCELL+1];
   side_type               sc [NCELL+1];
   logic [NQ-1:0][2*W-1:0] pc [NCELL+1];

   logic signed [W-1:0] r_low, r_upp;
   logic [7:0]          flags;
   logic [1:0]          err;

   // pipe moves when output is empty or being taken
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   iau_front u_front (
      .clock, .reset, .enable,
      .valid_in (req_tvalid && req_tready),
      .func     (req_tdata[3:0]),
      .a_low    (req_tdata[35:4]),
      .a_upp    (req_tdata[67:36]),
      .b_low    (req_tdata[99:68]),
      .b_upp    (req_tdata[131:100]),
      .valid_out(vf), .lane_out(lf), .side_out(sf), .prod_out(pf)
   );

   assign vc[0] = vf;
   assign lc[0] = lf;
   assign sc[0] = sf;
   assign pc[0] = pf;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      iau_div_cell u_cell (
         .clock, .reset, .enable,
         .valid_in (vc[g]), .lane_in(lc[g]), .side_in(sc[g]), .prod_in(pc[g]),
         .valid_out(vc[g+1]), .lane_out(lc[g+1]), .side_out(sc[g+1]),
         .prod_out(pc[g+1])
      );
   end

   iau_back u_back (
      .clock, .reset, .enable,
      .valid_in (vc[NCELL]), .lane_in(lc[NCELL]), .side_in(sc[NCELL]),
      .prod_in  (pc[NCELL]),
      .valid_out(rsp_tvalid),
      .r_low(r_low), .r_upp(r_upp), .cmp_flags(flags), .error(err)
   );

   assign rsp_tdata = {6'b0, err, flags, r_upp, r_low};

endmodule

FILE: sv/iau_checker.sv
// port-level checks for the interval arithmetic unit, bound to the top level
module iau_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [79:0]  rsp_tdata
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output word changed while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[73:72] != 2'd3)
      else $error("bad error code");

   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[71:64] != 8'h00 |-> rsp_tdata[73:72] == 2'd0)
      else $error("flags with error");

endmodule

bind interval_arithmetic_unit iau_checker u_iau_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

FILE: tb/tb_iau_checker.sv
// result checker for the interval arithmetic unit: predicts each word and compares
`timescale 1ns / 1ps

module tb_iau_checker
   import iau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [79:0]  rsp_tdata,
   output int           fail_count,
   output int           pending
);

   typedef struct {
      logic [31:0] r_low;
      logic [31:0] r_upp;
      logic [7:0]  flags;
      logic [1:0]  err;
   } interval_result_type;

   interval_result_type result_fifo[$];

   localparam longint HI_LIM = 64'sd2147483647;
   localparam longint LO_LIM = -64'sd2147483648;
   localparam longint ONE_Q  = 64'sd65536;

   function automatic longint clamp32(input longint v, inout logic [1:0] err);
      if (v > HI_LIM) begin
         err = ERR_OVF;
         return HI_LIM;
      end
      if (v < LO_LIM) begin
         err = ERR_OVF;
         return LO_LIM;
      end
      return v;
   endfunction

   // product rounded toward minus infinity
   function automatic longint q_mul(input longint a, input longint b,
                                    inout logic [1:0] err);
      longint p;
      p = a * b;
      return clamp32(p >>> FRAC, err);
   endfunction

   // quotient rounded toward minus infinity, divisor nonzero
   function automatic longint q_div(input longint a, input longint b,
                                    inout logic [1:0] err);
      longint n, d, q;
      logic   neg;
      n = (a < 0 ? -a : a) <<< FRAC;
      d = b < 0 ? -b : b;
      q = n / d;
      neg = (a < 0) != (b < 0);
      if (neg) q = -(q + ((n % d) != 0 ? 1 : 0));
      return clamp32(q, err);
   endfunction

   function automatic interval_result_type predict_interval(input logic [135:0] w);
      interval_result_type res;
      logic [3:0] fn;
      longint al, au, bl, bu, rl, ru;
      longint v[4];
      logic [1:0] err;
      fn = w[3:0];
      al = longint'($signed(w[35:4]));
      au = longint'($signed(w[67:36]));
      bl = longint'($signed(w[99:68]));
      bu = longint'($signed(w[131:100]));
      rl = 0;
      ru = 0;
      err = ERR_NONE;
      res.flags = 8'h00;
      case (fn)
         FN_ADD: begin
            rl = clamp32(al + bl, err);
            ru = clamp32(au + bu, err);
         end
         FN_SUB: begin
            rl = clamp32(al - bu, err);
            ru = clamp32(au - bl, err);
         end
         FN_MUL, FN_DIV: begin
            if (fn == FN_DIV && (bl == 0 || bu == 0)) begin
               rl = LO_LIM;
               ru = HI_LIM;
               err = ERR_DIV0;
            end else begin
               if (fn == FN_MUL) begin
                  v[0] = q_mul(al, bl, err); v[1] = q_mul(al, bu, err);
                  v[2] = q_mul(au, bl, err); v[3] = q_mul(au, bu, err);
               end else begin
                  v[0] = q_div(al, bl, err); v[1] = q_div(al, bu, err);
                  v[2] = q_div(au, bl, err); v[3] = q_div(au, bu, err);
               end
               rl = v[0];
               ru = v[0];
               for (int i = 1; i < 4; i++) begin
                  if (v[i] < rl) rl = v[i];
                  if (v[i] > ru) ru = v[i];
               end
            end
         end
         FN_INV: begin
            if (al == 0 || au == 0) begin
               rl = LO_LIM;
               ru = HI_LIM;
               err = ERR_DIV0;
            end else begin
               rl = q_div(ONE_Q, au, err);
               ru = q_div(ONE_Q, al, err);
            end
         end
         FN_INC: begin
            rl = clamp32(al + ONE_Q, err);
            ru = clamp32(au + ONE_Q, err);
         end
         FN_DEC: begin
            rl = clamp32(al - ONE_Q, err);
            ru = clamp32(au - ONE_Q, err);
         end
         FN_NEG: begin
            rl = clamp32(-au, err);
            ru = clamp32(-al, err);
         end
         FN_CMP: begin
            if (al == bl && au == bu)      res.flags = F_EQ | F_GE | F_LE | F_IN | F_OUT;
            else if (al >= bu)             res.flags = F_GT | F_NE;
            else if (al >= bl && au >= bu) res.flags = F_GE;
            else if (au <= bl)             res.flags = F_LT | F_NE;
            else if (al <= bl && au <= bu) res.flags = F_LE;
            else if (al >= bl && au <= bu) res.flags = F_IN;
            else if (al <= bl && au >= bu) res.flags = F_OUT;
         end
         default: ;
      endcase
      res.r_low = rl[31:0];
      res.r_upp = ru[31:0];
      res.err = err;
      return res;
   endfunction

   initial fail_count = 0;
   assign pending = result_fifo.size();

   always @(posedge clock) begin
      interval_result_type exp_res;
      int errs;
      errs = 0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_fifo.size() == 0) begin
               $error("result word with no expectation: %h", rsp_tdata);
               errs++;
            end else begin
               exp_res = result_fifo.pop_front();
               if (rsp_tdata[31:0] !== exp_res.r_low) begin
                  $error("r_low expected %h actual %h", exp_res.r_low, rsp_tdata[31:0]);
                  errs++;
               end
               if (rsp_tdata[63:32] !== exp_res.r_upp) begin
                  $error("r_upp expected %h actual %h", exp_res.r_upp, rsp_tdata[63:32]);
                  errs++;
               end
               if (rsp_tdata[71:64] !== exp_res.flags) begin
                  $error("cmp_flags expected %h actual %h", exp_res.flags,
                         rsp_tdata[71:64]);
                  errs++;
               end
               if (rsp_tdata[73:72] !== exp_res.err) begin
                  $error("error expected %0d actual %0d", exp_res.err, rsp_tdata[73:72]);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready)
            result_fifo.push_back(predict_interval(req_tdata));
      end
      if (errs != 0)
         fail_count <= fail_count + errs;
   end

endmodule

FILE: tb/tb.sv
// testbench top for the interval arithmetic unit: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb
   import iau_pkg::*;
();

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   int           fail_count;
   int           pending;
   logic         no_idle = 1'b0;   // set during the stretch where neither side idles

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   interval_arithmetic_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tb_iau_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver stalls with a probability of about 38 percent, except in the no-idle stretch
   always @(negedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 38);

   // one word per call; random gaps before it, held until accepted
   // valid stays up after the handshake so that back-to-back words need no gap
   task automatic send_word(input logic [3:0] fn, input logic [31:0] al,
                            input logic [31:0] au, input logic [31:0] bl,
                            input logic [31:0] bu);
      while (!no_idle && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, bu, bl, au, al, fn};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // bound values biased toward small numbers, fractions and the extremes
   function automatic logic [31:0] pick_bound();
      case ($urandom_range(5))
         0, 1: return $urandom();
         2: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
         3: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
         4: return $urandom_range(3) == 0 ? MAXV : $urandom_range(2) == 0 ? MINV :
                   $urandom_range(1) == 0 ? 32'd0 : ($urandom_range(1) ? ONE : -ONE);
         default: return 32'($signed($urandom_range(64)) - 32);
      endcase
   endfunction

   initial begin
      logic [3:0]  fn;
      logic [31:0] al, au, bl, bu, t;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: overflow at each end for add, sub and mul
      send_word(FN_ADD, MAXV, MAXV, ONE, MAXV);
      send_word(FN_ADD, MINV, 32'd0, -ONE, 32'd5);
      send_word(FN_SUB, MINV, MAXV, MINV, MAXV);
      send_word(FN_MUL, MAXV, MAXV, MINV, MAXV);
      send_word(FN_MUL, -32'sd3, 32'd7, 32'd1, 32'd3);   // floor of tiny negative products
      send_word(FN_MUL, MINV, MINV, MINV, MINV);
      // division: zero low bound, zero upper bound, divisor spanning zero
      send_word(FN_DIV, ONE, ONE, 32'd0, ONE);
      send_word(FN_DIV, ONE, ONE, -ONE, 32'd0);
      send_word(FN_DIV, -ONE, 3 * ONE, -32'd3, 32'd7);
      send_word(FN_DIV, MAXV, MINV, 32'd1, -32'd1);
      // reciprocal: zero bound and a normal one
      send_word(FN_INV, 32'd0, ONE, 32'd0, 32'd0);
      send_word(FN_INV, 3 * ONE, -7 * ONE, 32'd0, 32'd0);
      send_word(FN_INC, MAXV, 32'd0, 32'd0, 32'd0);
      send_word(FN_DEC, MINV, 32'd0, 32'd0, 32'd0);
      send_word(FN_NEG, MINV, MAXV, 32'd0, 32'd0);
      // compare: equal, greater, greater-equal, less, less-equal, inside, outside
      send_word(FN_CMP, ONE, 2 * ONE, ONE, 2 * ONE);
      send_word(FN_CMP, 5 * ONE, 6 * ONE, ONE, 2 * ONE);
      send_word(FN_CMP, 2 * ONE, 6 * ONE, ONE, 3 * ONE);
      send_word(FN_CMP, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
      send_word(FN_CMP, ONE, 3 * ONE, 2 * ONE, 4 * ONE);
      send_word(FN_CMP, 2 * ONE, 3 * ONE, ONE, 4 * ONE);
      send_word(FN_CMP, ONE, 4 * ONE, 2 * ONE, 3 * ONE);
      send_word(FN_ADD, 5 * ONE, ONE, 2 * ONE, -ONE);    // reversed bounds
      send_word(4'hf, MAXV, MINV, MAXV, MINV);           // unknown opcode

      for (int n = 0; n < 2000; n++) begin
         no_idle <= (n >= 600 && n < 800);
         if (n == 1000) begin
            // hold off until the pipe has drained
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         fn = $urandom_range(19) == 0 ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
         al = pick_bound();
         au = pick_bound();
         bl = pick_bound();
         bu = pick_bound();
         if ($urandom_range(4) != 0) begin
            if ($signed(al) > $signed(au)) begin t = al; al = au; au = t; end
            if ($signed(bl) > $signed(bu)) begin t = bl; bl = bu; bu = t; end
         end
         if (fn == FN_CMP && $urandom_range(3) == 0) begin
            bl = al;
            if ($urandom_range(1)) bu = au;
         end
         send_word(fn, al, au, bl, bu);
      end

      req_tvalid <= 1'b0;
      no_idle <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
